// ===== hdl/fspa_pkg.sv =====
// Package for the fit-strategy pool allocator: sizes, codes and sequencer states.
// No dependencies.
package fspa_pkg;
  localparam int MaxEntries = 16;
  localparam int IdxW       = 4;
  localparam int CntW       = 5;
  localparam int AddrW      = 16;
  localparam int LenW       = 17;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] REG_POOL = 2'd0;
  localparam logic [1:0] REG_FIT  = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_STATS, S_OUT
  } state_t;
endpackage

// ===== hdl/fspa_table.sv =====
// Entry table of the pool allocator: start and length memories.
// Depends on fspa_pkg.
module fspa_table import fspa_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IdxW-1:0]  waddr,
  input  logic [AddrW-1:0] wstart,
  input  logic [LenW-1:0]  wlen,
  input  logic [IdxW-1:0]  raddr,
  output logic [AddrW-1:0] rstart,
  output logic [LenW-1:0]  rlen
);
  logic [AddrW-1:0] mem_start [MaxEntries];
  logic [LenW-1:0]  mem_len   [MaxEntries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_len[waddr]   <= wlen;
    end
    rstart <= mem_start[raddr];
    rlen   <= mem_len[raddr];
  end
endmodule

// ===== hdl/fit_strategy_pool_allocator.sv =====
// Pool allocator with first, best or worst fit, top level.
// Uses fspa_pkg and fspa_table.
//
// Usage: requests arrive on in_* (valid/ready); each gives one result item on
// out_* (valid/ready). pool_size and fit_strategy sit on an APB-style port,
// register 0 at 0x0, register 1 at 0x4; write only while idle.
// One request is handled at a time; in_ready is low while it is in work.
// The table is one registered-read memory, so every pass walks it in steps
// that first set the address and then compare the read data. An item passes
// through accept, scan, decide, shift, stats and out, in that order.
// An allocation shifts the entries after its gap up to make room; a free
// shifts the entries after the freed one down.
// A zero size or a full table skips the scan and goes to the stats walk.
// The result stays in an output register until taken; a stalled receiver
// just holds the block in the output state.
// Reset (rst_n low, synchronous) empties the table and restores
// pool_size 65536 and first fit. No clearing pass is needed: only entries
// below the live count are read.
module fit_strategy_pool_allocator import fspa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [15:0]      in_req_size,
  input  logic [15:0]      in_free_addr,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_alloc_addr,
  output logic [4:0]       out_active_count,
  output logic [16:0]      out_total_allocated,
  output logic [16:0]      out_free_bytes,
  output logic [16:0]      out_max_gap,
  output logic [4:0]       out_free_fragments,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  state_t state_r, state_nxt;

  logic [LenW-1:0]  pool_size_r;
  logic [1:0]       fit_r;
  logic [CntW-1:0]  count_r;
  logic             act_r;
  logic [LenW-1:0]  need_r;
  logic [AddrW-1:0] target_r;
  logic [CntW-1:0]  k_r;       // gap / entry walk index
  logic             rd_ok_r;   // memory read data is valid for k_r
  logic [LenW-1:0]  prev_end_r;
  logic             pick_ok_r;
  logic [CntW-1:0]  pick_r;
  logic [LenW-1:0]  pick_size_r, pick_begin_r;
  logic             found_r;
  logic [1:0]       status_r;
  logic [AddrW-1:0] addr_r;
  logic [LenW-1:0]  sum_r, largest_r;
  logic [CntW-1:0]  frags_r;
  logic [CntW-1:0]  sh_r;      // shift pointer
  logic             sh_rd_r;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [AddrW-1:0] wstart, rstart;
  logic [LenW-1:0]  wlen, rlen;

  fspa_table u_table (
    .clk, .we, .waddr, .wstart, .wlen, .raddr, .rstart, .rlen
  );

  // APB
  assign pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    case (paddr[2])
      1'b0:    prdata = {15'd0, pool_size_r};
      default: prdata = {30'd0, fit_r};
    endcase
  end

  logic [LenW-1:0] pool_lim;
  assign pool_lim = pool_size_r[16] ? 17'h10000 : pool_size_r;

  // Shared gap unit: gap k ends at entry k start (from memory) or pool limit.
  logic             last_gap;
  logic [LenW-1:0]  gap_end, gap_sz;
  logic [LenW-1:0]  ent_end;
  assign last_gap = (k_r == count_r);
  assign gap_end  = last_gap ? pool_lim : {1'b0, rstart};
  assign gap_sz   = (gap_end > prev_end_r) ? gap_end - prev_end_r : '0;
  assign ent_end  = {1'b0, rstart} + rlen;

  logic take;
  always_comb begin
    take = 1'b0;
    if (gap_sz >= need_r) begin
      unique case (fit_r)
        FIT_BEST:  take = !pick_ok_r || gap_sz < pick_size_r;
        FIT_WORST: take = !pick_ok_r || gap_sz > pick_size_r;
        default:   take = !pick_ok_r;
      endcase
    end
  end

  logic [LenW-1:0] req_al;
  assign req_al = ({1'b0, in_req_size} + 17'd7) & ~17'd7;

  // memory address / write control
  always_comb begin
    raddr  = k_r[IdxW-1:0];
    we     = 1'b0;
    waddr  = sh_r[IdxW-1:0];
    wstart = rstart;
    wlen   = rlen;
    if (state_r == S_SHIFT && status_r == ST_OK) begin
      if (!act_r) begin
        raddr = sh_r[IdxW-1:0] - 1'b1;
        if (sh_r == pick_r) begin
          we = 1'b1; wstart = pick_begin_r[AddrW-1:0]; wlen = need_r;
        end else we = sh_rd_r;
      end else begin
        raddr = sh_r[IdxW-1:0] + 1'b1;
        we    = sh_rd_r;
      end
    end
  end

  // next state
  logic scan_done, shift_done;
  assign scan_done  = rd_ok_r && (last_gap || (act_r && found_r));
  assign shift_done = act_r ? (sh_r + 5'd1 >= count_r) : (sh_r == pick_r);
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SCAN;
      S_SCAN:   if (status_r != ST_OK) state_nxt = S_STATS;
                else if (scan_done) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_SHIFT;
      S_SHIFT:  if (status_r != ST_OK || shift_done) state_nxt = S_STATS;
      S_STATS:  if (rd_ok_r && last_gap) state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
  end
  assign out_status          = status_r;
  assign out_alloc_addr      = addr_r;
  assign out_active_count    = count_r;
  assign out_total_allocated = sum_r;
  assign out_free_bytes      = (pool_lim > sum_r) ? pool_lim - sum_r : '0;
  assign out_max_gap         = largest_r;
  assign out_free_fragments  = frags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pool_size_r <= 17'h10000;
      fit_r       <= FIT_FIRST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_POOL[0]) pool_size_r <= pwdata[16:0];
        else fit_r <= pwdata[1:0];
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          act_r <= in_action; need_r <= req_al; target_r <= in_free_addr;
          k_r <= '0; rd_ok_r <= 1'b0; prev_end_r <= '0;
          pick_ok_r <= 1'b0; found_r <= 1'b0; addr_r <= '0;
          status_r <= ST_OK;
          if (!in_action) begin
            if (in_req_size == 16'd0) status_r <= ST_NOFIT;
            else if (count_r >= CntW'(MaxEntries)) status_r <= ST_FULL;
          end
        end
        S_SCAN: begin
          if (status_r != ST_OK) begin
            // early error skips the scan: set up the stats walk
            k_r <= '0; rd_ok_r <= 1'b0; prev_end_r <= '0;
            sum_r <= '0; largest_r <= '0; frags_r <= '0;
          end else if (!rd_ok_r) rd_ok_r <= 1'b1;
          else if (!act_r) begin
            if (take) begin
              pick_ok_r <= 1'b1; pick_r <= k_r;
              pick_size_r <= gap_sz; pick_begin_r <= prev_end_r;
            end
            prev_end_r <= ent_end;
            if (!last_gap) begin
              k_r <= k_r + 1'b1; rd_ok_r <= 1'b0;
            end
          end else begin
            if (!last_gap && rstart == target_r) begin
              found_r <= 1'b1; pick_r <= k_r;
            end else if (!last_gap) begin
              k_r <= k_r + 1'b1; rd_ok_r <= 1'b0;
            end
          end
        end
        S_DECIDE: begin
          sh_rd_r <= 1'b0;
          if (!act_r) begin
            if (!pick_ok_r) status_r <= ST_NOFIT;
            else addr_r <= pick_begin_r[AddrW-1:0];
            sh_r <= count_r;
          end else begin
            if (!found_r) status_r <= ST_NOTFOUND;
            sh_r <= pick_r;
          end
        end
        S_SHIFT: begin
          if (status_r != ST_OK) begin
          end else if (!act_r) begin
            if (sh_r == pick_r) count_r <= count_r + 1'b1;
            else if (!sh_rd_r) sh_rd_r <= 1'b1;
            else begin sh_r <= sh_r - 1'b1; sh_rd_r <= 1'b0; end
          end else begin
            if (shift_done) count_r <= count_r - 1'b1;
            else if (!sh_rd_r) sh_rd_r <= 1'b1;
            else begin sh_r <= sh_r + 1'b1; sh_rd_r <= 1'b0; end
          end
          if (state_nxt == S_STATS) begin
            k_r <= '0; rd_ok_r <= 1'b0; prev_end_r <= '0;
            sum_r <= '0; largest_r <= '0; frags_r <= '0;
          end
        end
        S_STATS: begin
          if (!rd_ok_r) rd_ok_r <= 1'b1;
          else begin
            if (gap_sz != '0) begin
              frags_r <= frags_r + 1'b1;
              if (gap_sz > largest_r) largest_r <= gap_sz;
            end
            if (!last_gap) begin
              sum_r <= sum_r + rlen; prev_end_r <= ent_end;
              k_r <= k_r + 1'b1; rd_ok_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
